// File: src/square_patrol_waypoint_sequencer_defines.svh
// Assertion macros shared by the square patrol sequencer checker.
`ifndef SQUARE_PATROL_WAYPOINT_SEQUENCER_DEFINES_SVH
`define SQUARE_PATROL_WAYPOINT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPWS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SPWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spws_pkg.sv
// Shared types, constants and helpers of the square patrol waypoint sequencer.
package spws_pkg;

  localparam int unsigned TICK_W = 24;

  // Squared distances are Q32.32; 0.04 m^2 and (1000 m)^2 in that format.
  localparam logic [63:0] NEAR_THRESH  = 64'd171798692;
  localparam logic [63:0] SEARCH_LIMIT = 64'h000F_4240_0000_0000;

  localparam logic [2:0] NO_VERTEX = 3'd4;

  // Square corners, clockwise from top-left.
  localparam logic [1:0] VTX_TL = 2'd0;
  localparam logic [1:0] VTX_TR = 2'd1;
  localparam logic [1:0] VTX_BR = 2'd2;
  localparam logic [1:0] VTX_BL = 2'd3;

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_HALF_SIDE   = 3'd2,
    CFG_FINAL_X     = 3'd3,
    CFG_FINAL_Y     = 3'd4,
    CFG_EMERGENCY_X = 3'd5,
    CFG_EMERGENCY_Y = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'b01,
    MODE_PATROL = 2'b10
  } mode_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               emergency_req;
    logic               stop_req;
    logic [23:0]        mission_ticks;
  } in_t;

  typedef struct packed {
    logic               cmd_valid;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic               patrol_active;
    logic [1:0]         vertex_now;
    logic               emergency_seen;
    logic               stop_seen;
  } out_t;

  // The two distinct x and y coordinates of the square's corners.
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
  } corners_t;

  // Request leaving the distance pipeline: the input plus per-corner results.
  typedef struct packed {
    in_t        item;
    logic [3:0] near;
    logic [1:0] pick;
  } dist_t;

  // Centre plus or minus half side, saturated to the 32 bit signed range.
  function automatic logic signed [31:0] sat_corner(input logic signed [31:0] c,
                                                    input logic [29:0] h,
                                                    input logic neg);
    logic signed [32:0] s;
    s = neg ? (33'(c) - $signed({3'b000, h})) : (33'(c) + $signed({3'b000, h}));
    if (!s[32] && s[31]) begin
      return 32'sh7FFF_FFFF;
    end else if (s[32] && !s[31]) begin
      return 32'sh8000_0000;
    end else begin
      return $signed(s[31:0]);
    end
  endfunction

endpackage

// File: src/spws_dist.sv
// Four-stage pipeline measuring the vehicle's squared distance to each corner.
module spws_dist import spws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_t      in_i,
  input  corners_t corners_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dist_t    out_o
);

  localparam logic [1:0] AX_L = 2'd0;
  localparam logic [1:0] AX_R = 2'd1;
  localparam logic [1:0] AY_T = 2'd2;
  localparam logic [1:0] AY_B = 2'd3;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  in_t   s1_q, s2_item_q, s3_item_q;
  dist_t s4_q;

  logic signed [31:0] cval [4];
  logic signed [31:0] pval [4];
  logic signed [32:0] d_ab [4];
  logic signed [32:0] d_ba [4];
  logic [32:0]        mag33 [4];

  logic [3:0][30:0] mag_d, mag_q;
  logic [3:0]       far_d, far_q, s3_far_q;
  logic [3:0][61:0] sq_d, sq_q;
  logic [3:0][63:0] d2;
  logic [3:0][3:0]  le;
  logic [3:0]       near_d, cand, win;
  logic [1:0]       pick_d;

  // A stage takes a new request when it is empty or its contents move on.
  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign out_valid_o = s4_valid_q;
  assign out_o       = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  // Axis differences; both directions are formed so the magnitude is a select.
  assign cval[AX_L] = corners_i.left;
  assign cval[AX_R] = corners_i.right;
  assign cval[AY_T] = corners_i.top;
  assign cval[AY_B] = corners_i.bottom;
  assign pval[AX_L] = s1_q.pos_x;
  assign pval[AX_R] = s1_q.pos_x;
  assign pval[AY_T] = s1_q.pos_y;
  assign pval[AY_B] = s1_q.pos_y;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_ab[i]  = 33'(cval[i]) - 33'(pval[i]);
      d_ba[i]  = 33'(pval[i]) - 33'(cval[i]);
      mag33[i] = d_ab[i][32] ? d_ba[i] : d_ab[i];
      // A difference of 2^31 or more saturates the distance.
      far_d[i] = mag33[i][32] | mag33[i][31];
      mag_d[i] = mag33[i][30:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_d[i] = 62'(mag_q[i]) * 62'(mag_q[i]);
    end
  end

  function automatic logic [63:0] corner_d2(input logic [61:0] sx, input logic [61:0] sy,
                                            input logic fx, input logic fy);
    logic [63:0] sum;
    sum = {2'b00, sx} + {2'b00, sy};
    return (fx || fy) ? '1 : sum;
  endfunction

  always_comb begin
    d2[VTX_TL] = corner_d2(sq_q[AX_L], sq_q[AY_T], s3_far_q[AX_L], s3_far_q[AY_T]);
    d2[VTX_TR] = corner_d2(sq_q[AX_R], sq_q[AY_T], s3_far_q[AX_R], s3_far_q[AY_T]);
    d2[VTX_BR] = corner_d2(sq_q[AX_R], sq_q[AY_B], s3_far_q[AX_R], s3_far_q[AY_B]);
    d2[VTX_BL] = corner_d2(sq_q[AX_L], sq_q[AY_B], s3_far_q[AX_L], s3_far_q[AY_B]);
    le = '0;
    for (int i = 0; i < 4; i++) begin
      near_d[i] = d2[i] < NEAR_THRESH;
      cand[i]   = d2[i] < SEARCH_LIMIT;
      for (int j = i + 1; j < 4; j++) begin
        le[i][j] = d2[i] <= d2[j];
      end
    end
    // A corner wins if it is strictly closer than every lower index and no
    // farther than every higher one, so the lowest index takes a tie.
    for (int k = 0; k < 4; k++) begin
      win[k] = cand[k];
      for (int j = 0; j < 4; j++) begin
        if (j < k) win[k] = win[k] & !le[j][k];
        if (j > k) win[k] = win[k] & le[k][j];
      end
    end
    priority if (win[VTX_TR]) begin
      pick_d = VTX_TR;
    end else if (win[VTX_BR]) begin
      pick_d = VTX_BR;
    end else if (win[VTX_BL]) begin
      pick_d = VTX_BL;
    end else begin
      pick_d = VTX_TL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) s1_q <= in_i;
    if (s2_ready) begin
      s2_item_q <= s1_q;
      mag_q     <= mag_d;
      far_q     <= far_d;
    end
    if (s3_ready) begin
      s3_item_q <= s2_item_q;
      sq_q      <= sq_d;
      s3_far_q  <= far_q;
    end
    if (s4_ready) begin
      s4_q.item <= s3_item_q;
      s4_q.near <= near_d;
      s4_q.pick <= pick_d;
    end
  end

endmodule

// File: src/square_patrol_waypoint_sequencer.sv
// Square patrol waypoint sequencer: a request passes through 4 distance pipeline stages,
// then the state and result stage, whose output register holds its result.
// Throughput is one request per cycle; while a result waits, empty stages still take
// requests, and the input stalls once all five stages hold one. Reset clears the pipeline,
// the patrol state and the last-sent corner mark, and loads the registers' defaults (half
// side 1 m).
module square_patrol_waypoint_sequencer import spws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [31:0] center_x_q, center_y_q, final_x_q, final_y_q;
  logic signed [31:0] emergency_x_q, emergency_y_q;
  logic [29:0]        half_side_q;
  corners_t           corners_q;

  mode_e               mode_q, mode_d;
  logic [1:0]          vertex_q, vertex_d;
  logic [2:0]          last_q, last_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;

  logic        dist_valid, res_ready, fire, out_valid_q;
  dist_t       dist_out;
  out_t        res, out_q;
  logic [1:0]  v_new;
  logic [TICK_W-1:0] dur;
  logic        v_right, v_top;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      half_side_q   <= 30'd65536;
      final_x_q     <= '0;
      final_y_q     <= '0;
      emergency_x_q <= '0;
      emergency_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:    center_x_q    <= cfg_data_i;
        CFG_CENTER_Y:    center_y_q    <= cfg_data_i;
        CFG_HALF_SIDE:   half_side_q   <= cfg_data_i[29:0];
        CFG_FINAL_X:     final_x_q     <= cfg_data_i;
        CFG_FINAL_Y:     final_y_q     <= cfg_data_i;
        CFG_EMERGENCY_X: emergency_x_q <= cfg_data_i;
        CFG_EMERGENCY_Y: emergency_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Corners follow the registers in the next cycle.
  always_ff @(posedge clk_i) begin
    corners_q.left   <= sat_corner(center_x_q, half_side_q, 1'b1);
    corners_q.right  <= sat_corner(center_x_q, half_side_q, 1'b0);
    corners_q.top    <= sat_corner(center_y_q, half_side_q, 1'b0);
    corners_q.bottom <= sat_corner(center_y_q, half_side_q, 1'b1);
  end

  spws_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .corners_i   (corners_q),
    .out_valid_o (dist_valid),
    .out_ready_i (res_ready),
    .out_o       (dist_out)
  );

  assign res_ready = !out_valid_q || out_ready_i;
  assign fire      = dist_valid && res_ready;

  assign dur     = TICK_W'(dist_out.item.mission_ticks);
  assign v_new   = dist_out.near[vertex_q] ? vertex_q + 2'd1 : vertex_q;
  assign v_right = (v_new == VTX_TR) || (v_new == VTX_BR);
  assign v_top   = (v_new == VTX_TL) || (v_new == VTX_TR);

  always_comb begin
    mode_d   = mode_q;
    vertex_d = vertex_q;
    last_d   = last_q;
    ticks_d  = ticks_q;
    res      = '0;
    priority if (dist_out.item.emergency_req || dist_out.item.stop_req) begin
      res.cmd_valid = 1'b1;
      res.target_x  = dist_out.item.emergency_req ? emergency_x_q : dist_out.item.pos_x;
      res.target_y  = dist_out.item.emergency_req ? emergency_y_q : dist_out.item.pos_y;
      mode_d        = MODE_IDLE;
      ticks_d       = '0;
    end else if (mode_q == MODE_IDLE) begin
      if (dur != '0) begin
        vertex_d = dist_out.pick;
        ticks_d  = dur;
        mode_d   = MODE_PATROL;
      end
    end else if (ticks_q != '0) begin
      vertex_d = v_new;
      // The mark survives requests and patrol ends, so a restart at the same
      // corner stays silent until the corner changes.
      if ({1'b0, v_new} != last_q) begin
        res.cmd_valid = 1'b1;
        res.target_x  = v_right ? corners_q.right : corners_q.left;
        res.target_y  = v_top ? corners_q.top : corners_q.bottom;
        last_d        = {1'b0, v_new};
      end
      ticks_d = TICK_W'(ticks_q - 1'b1);
    end else begin
      res.cmd_valid = 1'b1;
      res.target_x  = final_x_q;
      res.target_y  = final_y_q;
      mode_d        = MODE_IDLE;
    end
    res.patrol_active  = (mode_d == MODE_PATROL);
    res.vertex_now     = vertex_d;
    res.emergency_seen = dist_out.item.emergency_req;
    res.stop_seen      = dist_out.item.stop_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      vertex_q    <= VTX_TL;
      last_q      <= NO_VERTEX;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready) out_valid_q <= dist_valid;
      if (fire) begin
        mode_q   <= mode_d;
        vertex_q <= vertex_d;
        last_q   <= last_d;
        ticks_q  <= ticks_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: src/spws_check.sv
// Port-level checker for the square patrol waypoint sequencer, with its bind.
`include "square_patrol_waypoint_sequencer_defines.svh"

module spws_check import spws_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  // Any request ends the patrol and always commands a position.
  `SPWS_ASSERT_IMPLIES(a_req_ends_patrol, out_valid_o && (out_o.emergency_seen || out_o.stop_seen), out_o.cmd_valid && !out_o.patrol_active, "request did not command and stop the patrol")

  // Without a command the target fields read as zero.
  `SPWS_ASSERT_IMPLIES(a_idle_target_zero, out_valid_o && !out_o.cmd_valid, (out_o.target_x == 0) && (out_o.target_y == 0), "target not zero without a command")

  `SPWS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o), "stalled result changed or vanished")

endmodule

bind square_patrol_waypoint_sequencer spws_check u_spws_check (.*);

// File: dv/patrol_cmd_checker.sv
// Checker that predicts and compares every result of the square patrol sequencer.
`timescale 1ns / 100ps
module patrol_cmd_checker import spws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam longint AXIS_FAR = 64'sd2147483648;

  // Register copy, updated as writes are accepted.
  logic signed [31:0] center_x  = '0;
  logic signed [31:0] center_y  = '0;
  logic [29:0]        half_side = 30'd65536;
  logic signed [31:0] final_x   = '0;
  logic signed [31:0] final_y   = '0;
  logic signed [31:0] emerg_x   = '0;
  logic signed [31:0] emerg_y   = '0;

  // Patrol state as the block should hold it.
  logic              on_patrol  = 1'b0;
  logic [1:0]        vertex     = VTX_TL;
  logic [2:0]        last_sent  = NO_VERTEX;
  logic [TICK_W-1:0] ticks_left = '0;

  out_t        expected_cmds[$];
  int unsigned mismatches = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Corner coordinates from the registers as they stand, saturated to 32 bits.
  function automatic void corner_of(input logic [1:0] k, output logic signed [31:0] x,
                                    output logic signed [31:0] y);
    longint h;
    h = longint'(half_side);
    x = clamp32((k == VTX_TR || k == VTX_BR) ? longint'(center_x) + h
                                              : longint'(center_x) - h);
    y = clamp32((k == VTX_TL || k == VTX_TR) ? longint'(center_y) + h
                                              : longint'(center_y) - h);
  endfunction

  // Exact Q32.32 squared distance; an axis gap of 2^31 or more saturates it.
  function automatic logic [63:0] sq_dist(input logic signed [31:0] ax,
                                          input logic signed [31:0] ay,
                                          input logic signed [31:0] bx,
                                          input logic signed [31:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx >= AXIS_FAR || dx <= -AXIS_FAR || dy >= AXIS_FAR || dy <= -AXIS_FAR) return '1;
    return dx * dx + dy * dy;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("%0t: patrol command mismatch on %s: got 0x%0h, want 0x%0h",
             $time, what, seen, wanted);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    in_t                t;
    out_t               got, want;
    logic signed [31:0] vx, vy;
    logic [63:0]        best, d;
    logic [1:0]         pick;
    if (!rst_ni) begin
      center_x   = '0;
      center_y   = '0;
      half_side  = 30'd65536;
      final_x    = '0;
      final_y    = '0;
      emerg_x    = '0;
      emerg_y    = '0;
      on_patrol  = 1'b0;
      vertex     = VTX_TL;
      last_sent  = NO_VERTEX;
      ticks_left = '0;
      expected_cmds.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_i;
        if (expected_cmds.size() == 0) begin
          report_mismatch("result with no request pending", got.target_x, '0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.cmd_valid !== want.cmd_valid)
            report_mismatch("cmd_valid", got.cmd_valid, want.cmd_valid);
          if (got.target_x !== want.target_x)
            report_mismatch("target_x", got.target_x, want.target_x);
          if (got.target_y !== want.target_y)
            report_mismatch("target_y", got.target_y, want.target_y);
          if (got.patrol_active !== want.patrol_active)
            report_mismatch("patrol_active", got.patrol_active, want.patrol_active);
          if (got.vertex_now !== want.vertex_now)
            report_mismatch("vertex_now", got.vertex_now, want.vertex_now);
          if (got.emergency_seen !== want.emergency_seen)
            report_mismatch("emergency_seen", got.emergency_seen, want.emergency_seen);
          if (got.stop_seen !== want.stop_seen)
            report_mismatch("stop_seen", got.stop_seen, want.stop_seen);
        end
      end

      if (in_valid_i && in_ready_i) begin
        t    = in_i;
        want = '0;
        want.emergency_seen = t.emergency_req;
        want.stop_seen      = t.stop_req;
        if (t.emergency_req || t.stop_req) begin
          // Emergency takes priority; either request ends the patrol.
          want.cmd_valid = 1'b1;
          want.target_x  = t.emergency_req ? emerg_x : t.pos_x;
          want.target_y  = t.emergency_req ? emerg_y : t.pos_y;
          on_patrol      = 1'b0;
          ticks_left     = '0;
        end else if (!on_patrol) begin
          if (t.mission_ticks != '0) begin
            best = SEARCH_LIMIT;
            pick = VTX_TL;
            for (int k = 0; k < 4; k++) begin
              corner_of(2'(k), vx, vy);
              d = sq_dist(vx, vy, t.pos_x, t.pos_y);
              if (d < best) begin
                best = d;
                pick = 2'(k);
              end
            end
            vertex     = pick;
            ticks_left = t.mission_ticks;
            on_patrol  = 1'b1;
          end
        end else if (ticks_left != '0) begin
          corner_of(vertex, vx, vy);
          if (sq_dist(vx, vy, t.pos_x, t.pos_y) < NEAR_THRESH) vertex = vertex + 2'd1;
          // The last-sent mark survives requests and patrol ends.
          if ({1'b0, vertex} != last_sent) begin
            corner_of(vertex, want.target_x, want.target_y);
            want.cmd_valid = 1'b1;
            last_sent      = {1'b0, vertex};
          end
          ticks_left = ticks_left - 1'b1;
        end else begin
          want.cmd_valid = 1'b1;
          want.target_x  = final_x;
          want.target_y  = final_y;
          on_patrol      = 1'b0;
        end
        want.patrol_active = on_patrol;
        want.vertex_now    = vertex;
        expected_cmds.push_back(want);
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CENTER_X:    center_x  = cfg_data_i;
          CFG_CENTER_Y:    center_y  = cfg_data_i;
          CFG_HALF_SIDE:   half_side = cfg_data_i[29:0];
          CFG_FINAL_X:     final_x   = cfg_data_i;
          CFG_FINAL_Y:     final_y   = cfg_data_i;
          CFG_EMERGENCY_X: emerg_x   = cfg_data_i;
          CFG_EMERGENCY_Y: emerg_y   = cfg_data_i;
          default: ;
        endcase
      end

      pending_o    <= expected_cmds.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// File: dv/tb_top.sv
// Stimulus, clocking and verdict for the square patrol waypoint sequencer.
`timescale 1ns / 100ps
module tb_top;
  import spws_pkg::*;

  localparam int ONE_M        = 65536;
  localparam int RESET_CYCLES = 12;
  localparam int SINK_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_idx_i   = '0;
  logic [31:0] cfg_data_i  = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          idling       = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  // Register values as last written, used only to aim positions at corners.
  logic [31:0] regs [7];

  square_patrol_waypoint_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  patrol_cmd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_i         (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i        (out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // A position within spread of corner k on each axis.
  function automatic void aim_near(input logic [1:0] k, input int spread,
                                   output logic signed [31:0] px,
                                   output logic signed [31:0] py);
    longint h, ox, oy;
    h  = longint'(regs[CFG_HALF_SIDE]);
    ox = longint'($urandom_range(2 * spread)) - spread;
    oy = longint'($urandom_range(2 * spread)) - spread;
    px = clamp32(longint'($signed(regs[CFG_CENTER_X])) +
                 ((k == VTX_TR || k == VTX_BR) ? h : -h) + ox);
    py = clamp32(longint'($signed(regs[CFG_CENTER_Y])) +
                 ((k == VTX_TL || k == VTX_TR) ? h : -h) + oy);
  endfunction

  function automatic logic [23:0] rand_ticks();
    case ($urandom_range(3))
      0, 1: return '0;
      2: return 24'($urandom_range(20, 1));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic emg, input logic stp, input logic [23:0] ticks);
    while (idling && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{pos_x: px, pos_y: py, emergency_req: emg, stop_req: stp,
                    mission_ticks: ticks};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic load_regs(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [29:0] h, input logic [31:0] fx,
                           input logic [31:0] fy, input logic [31:0] ex,
                           input logic [31:0] ey);
    logic [31:0] vals [7];
    cfg_idx_e    idx;
    vals = '{cx, cy, {2'b00, h}, fx, fy, ex, ey};
    idx  = idx.first();
    repeat (idx.num()) begin
      cfg_valid_i <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      regs[idx] = vals[idx];
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Start a patrol near one corner, then mostly walk the corners in order.
  task automatic patrol_run();
    logic signed [31:0] px, py;
    logic [1:0]         aim;
    int unsigned        dur, len, r;
    aim = 2'($urandom_range(3));
    dur = ($urandom_range(9) == 0) ? $urandom_range(24'hFF_FFFF, 1) : $urandom_range(12, 1);
    aim_near(aim, 9000, px, py);
    send_tick(px, py, 1'b0, 1'b0, 24'(dur));
    len = ((dur < 14) ? dur + 1 : 14) + $urandom_range(2);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_tick($urandom, $urandom, 1'b1, 1'($urandom_range(1)), rand_ticks());
      end else if (r < 6) begin
        send_tick($urandom, $urandom, 1'b0, 1'b1, rand_ticks());
      end else if (r < 24) begin
        send_tick($urandom, $urandom, 1'b0, 1'b0, rand_ticks());
      end else begin
        aim_near(aim, (r < 86) ? 9000 : ((r < 96) ? 13107 : 40000), px, py);
        send_tick(px, py, 1'b0, 1'b0, rand_ticks());
        aim = aim + 2'd1;
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        patrol_run();
      end else begin
        send_tick($urandom, $urandom, 1'(r < 80), 1'(r >= 78 && r < 86), rand_ticks());
      end
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= !idling || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    regs = '{default: '0};
    regs[CFG_HALF_SIDE] = ONE_M;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: corners at (+-1 m, +-1 m), final and emergency at the origin.
    send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1, 24'h00_0000);
    send_tick(12345, -777, 1'b1, 1'b0, 24'h00_0001);
    send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF);
    send_tick(ONE_M, ONE_M, 1'b0, 1'b0, 24'd3);
    send_tick(0, 0, 1'b0, 1'b0, 24'd0);
    send_tick(ONE_M + 13108, ONE_M, 1'b0, 1'b0, 24'd0);
    send_tick(ONE_M + 13107, ONE_M, 1'b0, 1'b0, 24'd0);
    send_tick(5, 5, 1'b0, 1'b0, 24'd0);
    // A new patrol at the corner sent last stays silent until it moves on.
    send_tick(ONE_M, -ONE_M, 1'b0, 1'b0, 24'd2);
    send_tick(0, 0, 1'b0, 1'b0, 24'd0);
    send_tick(ONE_M, -ONE_M + 9000, 1'b0, 1'b0, 24'd0);
    send_tick(ONE_M, ONE_M, 1'b0, 1'b1, 24'd7);
    // Equal distance to all corners: the lowest corner wins.
    send_tick(0, 0, 1'b0, 1'b0, 24'hFF_FFFF);
    send_tick(-ONE_M, ONE_M, 1'b0, 1'b0, 24'd0);
    send_tick(-ONE_M - 9000, ONE_M + 9000, 1'b0, 1'b0, 24'd0);
    send_tick(0, 0, 1'b1, 1'b0, 24'd0);
    // No corner within 1000 m, then an axis gap beyond the 32 bit range.
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0, 24'd1);
    send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0, 24'd0);
    send_tick(0, 0, 1'b0, 1'b0, 24'd0);
    send_tick(0, 0, 1'b0, 1'b0, 24'd0);
    run_random(items_sent + 100);
    drain();

    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: begin
          load_regs(5 * ONE_M, -3 * ONE_M, 2 * ONE_M, 10 * ONE_M, 10 * ONE_M,
                    -ONE_M, -2 * ONE_M);
        end
        2: begin
          load_regs(32'h7FFF_FFFF, 32'h8000_0000, 30'h3FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        end
        3: begin
          load_regs(32'h8000_0000, 32'h7FFF_FFFF, 30'd0, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        end
        default: begin
          load_regs(($urandom_range(3) == 0) ? $urandom : $urandom_range(200 * ONE_M) - 100 * ONE_M,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(200 * ONE_M) - 100 * ONE_M,
                    30'(($urandom_range(3) == 0) ? $urandom : $urandom_range(20 * ONE_M, 1)),
                    $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      // One phase without any idling; in another the result side holds off
      // long enough for the block to fill and stall its requests.
      idling = (p != 4);
      if (p == 5) hold_req = 1'b1;
      run_random(items_sent + PHASE_ITEMS);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
